@@ design/ptb_pkg.sv @@
// ---------------------------------------------------------------------------
// Priority tone buzzer package
// Shared constants, controller state type and the command and status
// structures that join the controller to the datapath.
// ---------------------------------------------------------------------------
package ptb_pkg;

   // Special tone codes.
   localparam logic [15:0] STOP_CODE      = 16'd0;
   localparam logic [15:0] PAUSE_CODE     = 16'd1;

   // Timer constants.
   localparam logic [15:0] TONE_BASE      = 16'd50000;
   localparam logic [15:0] SILENT_COMPARE = 16'd5000;
   localparam logic [1:0]  DEFAULT_VOLUME = 2'd2;

   // Operation codes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BUZZ = 1'b1;

   // Volume kinds.
   localparam logic [1:0] KIND_UI    = 2'd0;
   localparam logic [1:0] KIND_ALARM = 2'd1;
   localparam logic [1:0] KIND_HOUR  = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // Volume levels.
   localparam logic [1:0] VOL_OFF  = 2'd0;
   localparam logic [1:0] VOL_LOW  = 2'd1;
   localparam logic [1:0] VOL_MID  = 2'd2;
   localparam logic [1:0] VOL_HIGH = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_VOLUME_UI    = 2'd0;
   localparam logic [1:0] REG_VOLUME_ALARM = 2'd1;
   localparam logic [1:0] REG_VOLUME_HOUR  = 2'd2;

   // Divider: one quotient bit per step.
   localparam int          DIV_STEPS     = 16;
   localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Commands from the controller.
   typedef struct packed {
      logic load;      // capture the incoming item and seed the divider
      logic step;      // one restoring division step
      logic commit;    // update the state and load the result register
   } cmd_type;

   // Status towards the controller.
   typedef struct packed {
      logic need_div;  // the incoming item is a passing tone request
      logic out_free;  // the result register can take a new result
   } status_type;

endpackage

@@ design/ptb_if.sv @@
// ---------------------------------------------------------------------------
// Priority tone buzzer channels
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
interface ptb_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] length_ms;
   logic [15:0] tone;
   logic [1:0]  volume_kind;
   logic [2:0]  priority_req;
   logic        has_finish_hook;

   modport source (output valid, operation, length_ms, tone, volume_kind,
                   priority_req, has_finish_hook, input ready);
   modport sink   (input valid, operation, length_ms, tone, volume_kind,
                   priority_req, has_finish_hook, output ready);
endinterface

interface ptb_rsp_if;
   logic        valid;
   logic        ready;
   logic        pwm_enable;
   logic [15:0] period;
   logic [15:0] compare;
   logic        accepted;
   logic        finished;
   logic        busy_res;

   modport source (output valid, pwm_enable, period, compare, accepted,
                   finished, busy_res, input ready);
   modport sink   (input valid, pwm_enable, period, compare, accepted,
                   finished, busy_res, output ready);
endinterface

interface ptb_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] reg_index;
   logic [1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ design/ptb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Priority tone buzzer controller
// Sequences one item at a time: capture, optional division, result commit.
// ---------------------------------------------------------------------------
module ptb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ptb_pkg::status_type status,
   output ptb_pkg::cmd_type   cmd,
   output ptb_pkg::state_type state
);
   import ptb_pkg::*;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = status.need_div ? ST_DIVIDE : ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

@@ design/ptb_dp.sv @@
// ---------------------------------------------------------------------------
// Priority tone buzzer datapath
// Volume registers, buzzer state, the 50000/tone divider and the result
// register.
// ---------------------------------------------------------------------------
module ptb_dp (
   input  logic                clock,
   input  logic                reset,
   input  ptb_pkg::cmd_type    cmd,
   output ptb_pkg::status_type status,
   // Incoming item.
   input  logic                req_operation,
   input  logic [15:0]         req_length_ms,
   input  logic [15:0]         req_tone,
   input  logic [1:0]          req_volume_kind,
   input  logic [2:0]          req_priority_req,
   input  logic                req_has_finish_hook,
   // Register writes.
   input  logic                csr_write,
   input  logic [1:0]          csr_reg_index,
   input  logic [1:0]          csr_wdata,
   // Result.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_pwm_enable,
   output logic [15:0]         rsp_period,
   output logic [15:0]         rsp_compare,
   output logic                rsp_accepted,
   output logic                rsp_finished,
   output logic                rsp_busy_res
);
   import ptb_pkg::*;

   // Volume registers.
   logic [1:0] vol_ui_ff, vol_alarm_ff, vol_hour_ff;

   // Captured item.
   logic        op_ff;
   logic [15:0] len_ff, tone_ff;
   logic [1:0]  kind_ff;
   logic [2:0]  prio_ff;
   logic        hook_ff;

   // Buzzer state.
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [2:0]  cur_prio_ff, cur_prio_in;
   logic        hook_set_ff, hook_set_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] compare_ff, compare_in;
   logic        enabled_ff, enabled_in;

   // Divider.
   logic [15:0] rem_ff;
   logic [15:0] quo_ff;
   logic [16:0] rem_shift, rem_diff;

   // Result register.
   logic        rsp_valid_ff;
   logic        accepted_in, finished_in;
   logic        accepted_ff, finished_ff;
   logic        pwm_ff, busy_ff;
   logic [15:0] per_out_ff, cmp_out_ff;

   // Work values.
   logic [15:0] per;
   logic [1:0]  vol;
   logic [15:0] elapsed_inc;

   // Status towards the controller.
   assign status.need_div = (req_operation == OP_BUZZ) && (req_priority_req >= cur_prio_ff)
                            && (req_tone != STOP_CODE) && (req_tone != PAUSE_CODE)
                            && (req_tone != 16'd0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Volume registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ui_ff    <= DEFAULT_VOLUME;
         vol_alarm_ff <= DEFAULT_VOLUME;
         vol_hour_ff  <= DEFAULT_VOLUME;
      end else if (csr_write) begin
         if (csr_reg_index == REG_VOLUME_UI)    vol_ui_ff    <= csr_wdata;
         if (csr_reg_index == REG_VOLUME_ALARM) vol_alarm_ff <= csr_wdata;
         if (csr_reg_index == REG_VOLUME_HOUR)  vol_hour_ff  <= csr_wdata;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         len_ff  <= req_length_ms;
         tone_ff <= req_tone;
         kind_ff <= req_volume_kind;
         prio_ff <= req_priority_req;
         hook_ff <= req_has_finish_hook;
      end
   end

   // Restoring division of the tone base by the tone, one bit per step.
   // The partial remainder stays below the tone, so it fits in 16 bits.
   assign rem_shift = {rem_ff, quo_ff[15]};
   assign rem_diff  = rem_shift - {1'b0, tone_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         quo_ff <= TONE_BASE;
      end else if (cmd.step) begin
         if (!rem_diff[16]) begin
            rem_ff <= rem_diff[15:0];
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[15:0];
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
   end

   // Period, with a zero tone saturating to the base, and volume choice.
   assign per = (tone_ff == 16'd0) ? TONE_BASE : quo_ff;

   always_comb begin
      unique case (kind_ff)
         KIND_UI:    vol = vol_ui_ff;
         KIND_ALARM: vol = vol_alarm_ff;
         KIND_HOUR:  vol = vol_hour_ff;
         default:    vol = DEFAULT_VOLUME;
      endcase
   end

   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   // Next buzzer state for the captured item.
   always_comb begin
      remaining_in = remaining_ff;
      elapsed_in   = elapsed_ff;
      cur_prio_in  = cur_prio_ff;
      hook_set_in  = hook_set_ff;
      period_in    = period_ff;
      compare_in   = compare_ff;
      enabled_in   = enabled_ff;
      accepted_in  = 1'b0;
      finished_in  = 1'b0;
      if (op_ff == OP_TICK) begin
         elapsed_in = elapsed_inc;
         if (remaining_ff != 16'd0 && elapsed_inc >= remaining_ff) begin
            compare_in   = SILENT_COMPARE;
            enabled_in   = 1'b0;
            remaining_in = '0;
            cur_prio_in  = '0;
            finished_in  = hook_set_ff;
         end
      end else if (prio_ff >= cur_prio_ff) begin
         accepted_in = 1'b1;
         if (tone_ff == STOP_CODE) begin
            compare_in   = SILENT_COMPARE;
            enabled_in   = 1'b0;
            remaining_in = '0;
            cur_prio_in  = '0;
         end else begin
            cur_prio_in  = prio_ff;
            hook_set_in  = hook_ff;
            remaining_in = len_ff;
            elapsed_in   = '0;
            if (tone_ff == PAUSE_CODE) begin
               compare_in = SILENT_COMPARE;
               enabled_in = 1'b0;
            end else begin
               unique case (vol)
                  VOL_OFF:  compare_in = SILENT_COMPARE;
                  VOL_LOW:  compare_in = per >> 3;
                  VOL_MID:  compare_in = per >> 2;
                  VOL_HIGH: compare_in = per >> 1;
                  default:  compare_in = SILENT_COMPARE;
               endcase
               period_in  = per;
               enabled_in = 1'b1;
            end
         end
      end
   end

   // Buzzer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         elapsed_ff   <= '0;
         cur_prio_ff  <= '0;
         hook_set_ff  <= 1'b0;
         period_ff    <= '0;
         compare_ff   <= SILENT_COMPARE;
         enabled_ff   <= 1'b0;
      end else if (cmd.commit) begin
         remaining_ff <= remaining_in;
         elapsed_ff   <= elapsed_in;
         cur_prio_ff  <= cur_prio_in;
         hook_set_ff  <= hook_set_in;
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         enabled_ff   <= enabled_in;
      end
   end

   // Result register: loaded on commit, emptied by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pwm_ff      <= enabled_in;
         per_out_ff  <= period_in;
         cmp_out_ff  <= compare_in;
         accepted_ff <= accepted_in;
         finished_ff <= finished_in;
         busy_ff     <= (remaining_in != 16'd0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pwm_enable = pwm_ff;
   assign rsp_period     = per_out_ff;
   assign rsp_compare    = cmp_out_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_busy_res   = busy_ff;

endmodule

@@ design/priority_tone_buzzer_control.sv @@
// ---------------------------------------------------------------------------
// Priority tone buzzer control
// Keeps the enable, period and compare settings of a PWM tone generator.
//
// Channels: req_ch takes one item per transfer, either a one-millisecond
// tick or a buzz request; rsp_ch returns exactly one result per item with
// the current enable, period and compare and the accepted, finished and
// busy flags. csr_ch writes the three volume registers and is always ready.
// Sequence: a tick, a stop, a pause or an ignored request is captured and
// then committed from the emit state; a tone request first runs through the
// divider that forms 50000/tone one quotient bit per cycle. The block takes
// a new item only after the last one has been committed.
// A finished result waits in an output register, so the next item can be
// taken while the receiver stalls; that item then waits for the register
// to empty before it is committed.
// Reset clears all buzzer state, silences the tone (compare 5000) and sets
// every volume register to 2.
// ---------------------------------------------------------------------------
module priority_tone_buzzer_control (
   input logic clock,
   input logic reset,
   ptb_req_if.sink   req_ch,
   ptb_rsp_if.source rsp_ch,
   ptb_csr_if.sink   csr_ch
);
   import ptb_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;

   // Register writes are taken at once.
   assign csr_ch.ready = 1'b1;

   // Controller.
   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // Datapath.
   ptb_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_ch.operation),
      .req_length_ms       (req_ch.length_ms),
      .req_tone            (req_ch.tone),
      .req_volume_kind     (req_ch.volume_kind),
      .req_priority_req    (req_ch.priority_req),
      .req_has_finish_hook (req_ch.has_finish_hook),
      .csr_write           (csr_ch.valid),
      .csr_reg_index       (csr_ch.reg_index),
      .csr_wdata           (csr_ch.wdata),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_pwm_enable      (rsp_ch.pwm_enable),
      .rsp_period          (rsp_ch.period),
      .rsp_compare         (rsp_ch.compare),
      .rsp_accepted        (rsp_ch.accepted),
      .rsp_finished        (rsp_ch.finished),
      .rsp_busy_res        (rsp_ch.busy_res)
   );

   // A division runs through all its steps in the divide state and then emits.
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state == ST_DIVIDE && $past(state) != ST_DIVIDE)
      |-> ##15 (state == ST_DIVIDE) ##1 (state == ST_EMIT))
      else $error("divider did not run for sixteen cycles");

   // A finish always comes with the tone stopped and nothing pending.
   a_finish_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.finished) |-> (!rsp_ch.busy_res && !rsp_ch.pwm_enable))
      else $error("finish reported while the tone is still active");

   // A silenced output always carries the silent compare value.
   a_silent_compare: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.pwm_enable) |-> (rsp_ch.compare == SILENT_COMPARE))
      else $error("silent output without the silent compare value");

   // A request result never also reports a finish.
   a_accept_no_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.accepted) |-> !rsp_ch.finished)
      else $error("accepted request reported a finish");

endmodule
